FILE: hw/rtl/wsd_pkg.sv
// Shared types and codes for the WebSocket frame deframer.
package wsd_pkg;

  // Width of the kept payload length; extended length bytes above it are dropped.
  localparam int LENGTH_BITS = 64;

  typedef logic [LENGTH_BITS-1:0] wsd_len_t;

  // Result status codes
  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_SHORT    = 3'd2;
  localparam logic [2:0] ST_NOTFIN   = 3'd3;
  localparam logic [2:0] ST_UNMASKED = 3'd4;
  localparam logic [2:0] ST_TRUNC    = 3'd5;

  // One received byte with its buffer end mark
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } wsd_item_t;

  // One result transaction
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] payload_byte;
    logic       frame_last;
  } wsd_result_t;

  // Registered input byte handed to the parser
  typedef struct packed {
    logic      valid;
    wsd_item_t item;
  } wsd_step_t;

  // Parser outcome for the byte being processed
  typedef struct packed {
    logic        valid;
    wsd_result_t res;
  } wsd_outcome_t;

endpackage

FILE: hw/rtl/wsd_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
interface wsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface wsd_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] payload_byte;
  logic       frame_last;

  modport source (output valid, output status, output payload_byte, output frame_last,
                  input ready);
  modport sink   (input valid, input status, input payload_byte, input frame_last,
                  output ready);
endinterface

FILE: hw/rtl/wsd_parser.sv
// Frame header parser, length tracking and payload unmasking.
module wsd_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  wsd_pkg::wsd_step_t    step,
  output wsd_pkg::wsd_outcome_t outcome
);

  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_SECOND  = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;

  logic [2:0]        parse_phase, parse_phase_next;
  logic [3:0]        header_count, header_count_next;
  wsd_pkg::wsd_len_t length_remaining, length_remaining_next;
  logic [31:0]       mask_key, mask_key_next;
  logic [1:0]        mask_position, mask_position_next;

  logic [7:0]        b;
  logic              buf_end;
  logic [3:0]        hc_dec;
  wsd_pkg::wsd_len_t len_dec;
  logic [7:0]        unmasked;

  assign b        = step.item.rx_byte;
  assign buf_end  = step.item.buffer_end;
  assign hc_dec   = header_count - 4'd1;
  assign len_dec  = length_remaining - wsd_pkg::wsd_len_t'(1);
  assign unmasked = b ^ mask_key[{~mask_position, 3'b000} +: 8];

  always_comb begin
    parse_phase_next      = parse_phase;
    header_count_next     = header_count;
    length_remaining_next = length_remaining;
    mask_key_next         = mask_key;
    mask_position_next    = mask_position;
    outcome.valid         = 1'b0;
    outcome.res           = '{status: wsd_pkg::ST_DATA, payload_byte: 8'd0, frame_last: 1'b1};

    if (step.valid) begin
      case (parse_phase)
        PH_FIRST: begin
          if (buf_end) begin
            outcome.valid      = 1'b1;
            outcome.res.status = wsd_pkg::ST_SHORT;
          end else if (!b[7]) begin
            outcome.valid      = 1'b1;
            outcome.res.status = wsd_pkg::ST_NOTFIN;
            parse_phase_next   = PH_SKIP;
          end else begin
            parse_phase_next = PH_SECOND;
          end
        end
        PH_SECOND: begin
          if (!b[7]) begin
            outcome.valid      = 1'b1;
            outcome.res.status = wsd_pkg::ST_UNMASKED;
            parse_phase_next   = PH_SKIP;
          end else begin
            length_remaining_next = '0;
            mask_key_next         = '0;
            mask_position_next    = '0;
            if (b[6:0] == 7'd126) begin
              header_count_next = 4'd2;
              parse_phase_next  = PH_EXTLEN;
            end else if (b[6:0] == 7'd127) begin
              header_count_next = 4'd8;
              parse_phase_next  = PH_EXTLEN;
            end else begin
              length_remaining_next = wsd_pkg::wsd_len_t'(b[6:0]);
              header_count_next     = 4'd4;
              parse_phase_next      = PH_KEY;
            end
            if (buf_end) begin
              outcome.valid      = 1'b1;
              outcome.res.status = wsd_pkg::ST_TRUNC;
            end
          end
        end
        PH_EXTLEN: begin
          length_remaining_next = {length_remaining[wsd_pkg::LENGTH_BITS-9:0], b};
          header_count_next     = hc_dec;
          if (hc_dec == 4'd0) begin
            header_count_next = 4'd4;
            parse_phase_next  = PH_KEY;
          end
          if (buf_end) begin
            outcome.valid      = 1'b1;
            outcome.res.status = wsd_pkg::ST_TRUNC;
          end
        end
        PH_KEY: begin
          mask_key_next     = {mask_key[23:0], b};
          header_count_next = hc_dec;
          if (hc_dec == 4'd0) begin
            if (length_remaining == '0) begin
              outcome.valid      = 1'b1;
              outcome.res.status = wsd_pkg::ST_EMPTY;
              parse_phase_next   = PH_SKIP;
            end else begin
              parse_phase_next = PH_PAYLOAD;
              if (buf_end) begin
                outcome.valid      = 1'b1;
                outcome.res.status = wsd_pkg::ST_TRUNC;
              end
            end
          end else if (buf_end) begin
            outcome.valid      = 1'b1;
            outcome.res.status = wsd_pkg::ST_TRUNC;
          end
        end
        PH_PAYLOAD: begin
          mask_position_next       = mask_position + 2'd1;
          length_remaining_next    = len_dec;
          outcome.valid            = 1'b1;
          outcome.res.payload_byte = unmasked;
          if (len_dec == '0) begin
            parse_phase_next = PH_SKIP;
          end else if (buf_end) begin
            outcome.res.status = wsd_pkg::ST_TRUNC;
          end else begin
            outcome.res.frame_last = 1'b0;
          end
        end
        default: begin
          // trailing bytes: wait for the buffer end
        end
      endcase

      if (buf_end) begin
        parse_phase_next      = PH_FIRST;
        header_count_next     = '0;
        length_remaining_next = '0;
        mask_key_next         = '0;
        mask_position_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_FIRST;
      header_count     <= '0;
      length_remaining <= '0;
      mask_key         <= '0;
      mask_position    <= '0;
    end else begin
      parse_phase      <= parse_phase_next;
      header_count     <= header_count_next;
      length_remaining <= length_remaining_next;
      mask_key         <= mask_key_next;
      mask_position    <= mask_position_next;
    end
  end

endmodule

FILE: hw/rtl/wsd_out_stage.sv
// Result register driving the output channel.
module wsd_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  wsd_pkg::wsd_outcome_t outcome,
  output logic                  free,
  wsd_result_if.source          deframed
);

  logic                 full;
  wsd_pkg::wsd_result_t res;

  assign free                  = !full || deframed.ready;
  assign deframed.valid        = full;
  assign deframed.status       = res.status;
  assign deframed.payload_byte = res.payload_byte;
  assign deframed.frame_last   = res.frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= outcome.valid;
    end else if (deframed.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && outcome.valid) begin
      res <= outcome.res;
    end
  end

endmodule

FILE: hw/rtl/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer with payload unmasking.
//
//  channel   dir  payload                                  meaning
//  rx        in   rx_byte[7:0], buffer_end                 one buffer byte per transaction
//  deframed  out  status[2:0], payload_byte[7:0], frame_last  zero or one per byte
//
// One byte per cycle sustained while the output is not stalled. A byte is held in
// the input register, from which the parser updates its state and the outcome is
// captured in the result register, which drives the deframed channel.
// rst is synchronous: parser restarts at the first header byte, both registers empty.
// A stalled output holds the result register; the input register then fills and
// rx.ready drops until deframed.ready returns. Bytes that give no result still
// take one pass through the parser and need a free result slot to move on.
module websocket_frame_deframer (
  input  logic         clk,
  input  logic         rst,
  wsd_byte_if.sink     rx,
  wsd_result_if.source deframed
);

  logic                  in_full;
  wsd_pkg::wsd_item_t    in_item;
  logic                  out_free;
  logic                  advance;
  wsd_pkg::wsd_step_t    step;
  wsd_pkg::wsd_outcome_t outcome;

  // The held byte moves through the parser once the result slot can take it.
  assign advance  = in_full && out_free;
  assign rx.ready = !in_full || out_free;

  assign step.valid = advance;
  assign step.item  = in_item;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_item <= '{rx_byte: rx.rx_byte, buffer_end: rx.buffer_end};
    end
  end

  wsd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .outcome (outcome)
  );

  wsd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .outcome  (outcome),
    .free     (out_free),
    .deframed (deframed)
  );

endmodule
